### sv/bfcc_pkg.sv
// Shared constants and types for the box frustum clip classifier.
package bfcc_pkg;

  localparam int COORD_WIDTH_DEF     = 16;
  localparam int MATRIX_FRAC_DEF     = 12;
  localparam int COORD_FRAC_BITS     = 4;
  localparam int ELEM_W              = 16;
  localparam int ELEMS_PER_ROW       = 4;
  localparam int MAT_ROWS            = 4;
  localparam int CFG_DATA_W          = 64;
  localparam int CFG_IDX_W           = 3;
  localparam int NEAR_MODE_W         = 2;
  localparam int OUTCODE_W           = 6;
  localparam int RESULT_W            = 2;
  localparam int OUT_DATA_W          = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_ZERO  = 3'd0,
    CFG_ROW_ONE   = 3'd1,
    CFG_ROW_TWO   = 3'd2,
    CFG_ROW_THREE = 3'd3,
    CFG_NEAR_MODE = 3'd4
  } cfg_idx_e;

  typedef enum logic [NEAR_MODE_W-1:0] {
    NEAR_NONE  = 2'd0,
    NEAR_Z_NEG = 2'd1,
    NEAR_Z_ONE = 2'd2
  } near_mode_e;

  typedef enum logic [RESULT_W-1:0] {
    CLIP_INSIDE  = 2'd0,
    CLIP_CLIPPED = 2'd1,
    CLIP_OUTSIDE = 2'd2
  } clip_e;

  // outcode bit positions
  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_BOTTOM = 2;
  localparam int OC_TOP    = 3;
  localparam int OC_FAR    = 4;
  localparam int OC_NEAR   = 5;

  localparam logic [CFG_DATA_W-1:0] ROW_ZERO_RST  = 64'h0000_0000_0000_1000;
  localparam logic [CFG_DATA_W-1:0] ROW_ONE_RST   = 64'h0000_0000_1000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW_TWO_RST   = 64'h0000_1000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW_THREE_RST = 64'h1000_0000_0000_0000;
  localparam logic [NEAR_MODE_W-1:0] NEAR_MODE_RST = NEAR_Z_ONE;

endpackage

### sv/box_frustum_clip_classify.sv
// Box frustum clip classifier: corner transform, outcode test and reduce.
//
//  channel  | dir | width              | contents
//  ---------+-----+--------------------+-------------------------------------
//  s_axis   | in  | 6*COORD_WIDTH pad8 | min_x min_y min_z max_x max_y max_z
//  m_axis   | out | 8                  | clip_result
//  cfg      | in  | 3 + 64             | row 0..3 of the matrix, near mode
//
// Two register stages: the input word and the result. The 24 axis products,
// the 32 clip coordinates, the plane tests and the AND/OR reduce sit between
// them. One word in per cycle while m_axis_tready is high. Each stage loads
// when empty or when the next one moves, so words keep entering while a
// result waits until both stages hold a word.
// Reset empties both stages and loads the identity matrix with near mode 2.
module box_frustum_clip_classify #(
  parameter int COORD_WIDTH          = bfcc_pkg::COORD_WIDTH_DEF,
  parameter int MATRIX_FRACTION_BITS = bfcc_pkg::MATRIX_FRAC_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z from bit 0 up, zero padded
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // clip_result in bits 1:0, rest zero
  output logic [bfcc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  input  logic                                   cfg_we_i,
  input  logic [bfcc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [bfcc_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import bfcc_pkg::*;

  localparam int PROD_W  = COORD_WIDTH + ELEM_W;
  localparam int TR_W    = ELEM_W + COORD_FRAC_BITS;
  localparam int SUM_W   = PROD_W + 2;
  localparam int CMP_W   = SUM_W + 1;
  localparam int CLIP_FB = COORD_FRAC_BITS + MATRIX_FRACTION_BITS;
  localparam int NEAR_W  = (SUM_W > CLIP_FB + 1) ? SUM_W : CLIP_FB + 1;
  // all ones shifted up: -1.0 in clip scale
  localparam logic signed [NEAR_W-1:0] NEG_ONE_CLIP = {NEAR_W{1'b1}} << CLIP_FB;

  // configuration
  logic [CFG_DATA_W-1:0]  mat_q [MAT_ROWS];
  logic [NEAR_MODE_W-1:0] near_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0]    <= ROW_ZERO_RST;
      mat_q[1]    <= ROW_ONE_RST;
      mat_q[2]    <= ROW_TWO_RST;
      mat_q[3]    <= ROW_THREE_RST;
      near_mode_q <= NEAR_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_ZERO:  mat_q[0] <= cfg_data_i;
        CFG_ROW_ONE:   mat_q[1] <= cfg_data_i;
        CFG_ROW_TWO:   mat_q[2] <= cfg_data_i;
        CFG_ROW_THREE: mat_q[3] <= cfg_data_i;
        CFG_NEAR_MODE: near_mode_q <= cfg_data_i[NEAR_MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: a stage loads when empty or when its successor loads
  logic v1_q, v2_q;
  logic rdy1, rdy2;

  assign rdy2 = !v2_q || m_axis_tready;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // input register: box bounds, [axis][0 = min, 1 = max]
  logic signed [COORD_WIDTH-1:0] box_q [3][2];

  // per axis, per bound, per column products
  logic signed [PROD_W-1:0] prod [3][2][ELEMS_PER_ROW];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 2; b++) begin
        for (int c = 0; c < ELEMS_PER_ROW; c++) begin
          prod[a][b][c] = PROD_W'(box_q[a][b]) *
                          PROD_W'($signed(mat_q[a][c*ELEM_W +: ELEM_W]));
        end
      end
    end
  end

  // clip coordinates, [corner][column]
  logic signed [SUM_W-1:0] clip  [8][ELEMS_PER_ROW];
  logic signed [TR_W-1:0]  trans [ELEMS_PER_ROW];

  always_comb begin
    for (int c = 0; c < ELEMS_PER_ROW; c++) begin
      // translation row times the constant 1.0 in coordinate scale
      trans[c] = {$signed(mat_q[3][c*ELEM_W +: ELEM_W]), {COORD_FRAC_BITS{1'b0}}};
    end
    for (int k = 0; k < 8; k++) begin
      for (int c = 0; c < ELEMS_PER_ROW; c++) begin
        clip[k][c] = SUM_W'(prod[0][k[0]][c])
                   + SUM_W'(prod[1][k[1]][c])
                   + SUM_W'(prod[2][k[2]][c])
                   + SUM_W'(trans[c]);
      end
    end
  end

  // outcodes, AND/OR over corners, classify
  logic [OUTCODE_W-1:0]   and_code, or_code;
  logic [OUTCODE_W-1:0]   code;
  logic signed [CMP_W-1:0] qx, qy, qz, qw;
  logic signed [NEAR_W-1:0] qz_n;
  clip_e                  result_d;
  logic [RESULT_W-1:0]    result_q;

  always_comb begin
    and_code = '1;
    or_code  = '0;
    for (int k = 0; k < 8; k++) begin
      qx   = CMP_W'(clip[k][0]);
      qy   = CMP_W'(clip[k][1]);
      qz   = CMP_W'(clip[k][2]);
      qw   = CMP_W'(clip[k][3]);
      qz_n = NEAR_W'(clip[k][2]);
      code = '0;
      code[OC_LEFT]   = (qx + qw) < 0;
      code[OC_RIGHT]  = qx > qw;
      code[OC_BOTTOM] = (qy + qw) < 0;
      code[OC_TOP]    = qy > qw;
      code[OC_FAR]    = qz > qw;
      case (near_mode_q)
        NEAR_Z_NEG: code[OC_NEAR] = qz < 0;
        NEAR_Z_ONE: code[OC_NEAR] = qz_n < NEG_ONE_CLIP;
        default:    code[OC_NEAR] = 1'b0;
      endcase
      and_code = and_code & code;
      or_code  = or_code | code;
    end
    if (or_code == '0) begin
      result_d = CLIP_INSIDE;
    end else if (and_code != '0) begin
      result_d = CLIP_OUTSIDE;
    end else begin
      result_d = CLIP_CLIPPED;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      for (int a = 0; a < 3; a++) begin
        box_q[a][0] <= s_axis_tdata[a*COORD_WIDTH +: COORD_WIDTH];
        box_q[a][1] <= s_axis_tdata[(a+3)*COORD_WIDTH +: COORD_WIDTH];
      end
    end
    if (rdy2 && v1_q) result_q <= result_d;
  end

  assign m_axis_tdata = {{(OUT_DATA_W-RESULT_W){1'b0}}, result_q};

endmodule
